// ----- rtl/turn_indicator_controller_top_macros.svh -----
// Assertion macros for the turn indicator controller top level.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef TURN_INDICATOR_CONTROLLER_TOP_MACROS_SVH
`define TURN_INDICATOR_CONTROLLER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("turn indicator assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("turn indicator assertion failed");

`endif

// ----- rtl/tic_pkg.sv -----
// Shared types and constants for the turn indicator controller.
// No dependencies; imported by every module of the block.
package tic_pkg;

  localparam int unsigned CntW = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CntW-1:0] HoldTicksRst  = 4'd10;
  localparam logic [CntW-1:0] BlinkTicksRst = 4'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHoldTicks  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegBlinkTicks = 1'b1;

  typedef struct packed {
    logic left_press;
    logic right_press;
  } tic_in_t;

  typedef struct packed {
    logic left_lamp;
    logic right_lamp;
  } tic_out_t;

  typedef struct packed {
    logic [CntW-1:0] hold_ticks;
    logic [CntW-1:0] blink_ticks;
  } tic_cfg_t;

  typedef struct packed {
    logic left_on;
    logic right_on;
    logic hazard_on;
  } tic_mode_t;

  // a zero limit behaves as one
  function automatic logic [CntW-1:0] limit_of(input logic [CntW-1:0] reg_val);
    return (reg_val == '0) ? CntW'(1) : reg_val;
  endfunction

endpackage

// ----- rtl/tic_cfg.sv -----
// Configuration registers of the turn indicator controller.
// Depends on tic_pkg.
module tic_cfg
  import tic_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CntW-1:0]    cfg_wdata,
  output tic_cfg_t           cfg
);

  tic_cfg_t cfg_r;
  tic_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        RegHoldTicks:  cfg_nxt.hold_ticks  = cfg_wdata;
        RegBlinkTicks: cfg_nxt.blink_ticks = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks  <= HoldTicksRst;
      cfg_r.blink_ticks <= BlinkTicksRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/tic_core.sv -----
// Per-tick state update: hold counters, side/hazard modes, blink divider.
// Depends on tic_pkg. Lamp values are the post-update view of the state.
module tic_core
  import tic_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  tic_in_t   press,
  input  tic_cfg_t  cfg,
  output tic_out_t  lamps_nxt,
  output tic_mode_t mode
);

  logic [CntW-1:0] left_hold_r, left_hold_nxt;
  logic [CntW-1:0] right_hold_r, right_hold_nxt;
  logic [CntW-1:0] blink_count_r, blink_count_nxt;
  logic            blink_phase_r, blink_phase_nxt;
  tic_mode_t       mode_r, mode_nxt;

  always_comb begin
    logic [CntW-1:0] hl;
    logic [CntW-1:0] bl;
    logic [CntW-1:0] cnt_inc;
    tic_mode_t       m;

    hl = limit_of(cfg.hold_ticks);
    bl = limit_of(cfg.blink_ticks);
    m  = mode_r;

    // left button first
    left_hold_nxt = left_hold_r;
    if (press.left_press) begin
      if (left_hold_r < hl) left_hold_nxt = left_hold_r + CntW'(1);
    end else begin
      if (left_hold_r >= hl) begin
        priority if (m.hazard_on) begin
          m.hazard_on = 1'b0;
          m.left_on   = 1'b1;
          m.right_on  = 1'b0;
        end else if (m.right_on) begin
          m.right_on = 1'b0;
          m.left_on  = 1'b1;
        end else begin
          m.left_on = ~m.left_on;
        end
      end
      left_hold_nxt = '0;
    end

    // then the right button, seeing the left's effect
    right_hold_nxt = right_hold_r;
    if (press.right_press) begin
      if (right_hold_r < hl) right_hold_nxt = right_hold_r + CntW'(1);
    end else begin
      if (right_hold_r >= hl) begin
        priority if (m.hazard_on) begin
          m.hazard_on = 1'b0;
          m.right_on  = 1'b1;
          m.left_on   = 1'b0;
        end else if (m.left_on) begin
          m.left_on  = 1'b0;
          m.right_on = 1'b1;
        end else begin
          m.right_on = ~m.right_on;
        end
      end
      right_hold_nxt = '0;
    end

    // both held fully: hazard
    if (press.left_press && press.right_press &&
        left_hold_nxt >= hl && right_hold_nxt >= hl) begin
      m.hazard_on = 1'b1;
      m.left_on   = 1'b0;
      m.right_on  = 1'b0;
    end
    mode_nxt = m;

    cnt_inc = blink_count_r + CntW'(1);
    if (cnt_inc >= bl) begin
      blink_count_nxt = '0;
      blink_phase_nxt = ~blink_phase_r;
    end else begin
      blink_count_nxt = cnt_inc;
      blink_phase_nxt = blink_phase_r;
    end

    lamps_nxt.left_lamp  = (m.left_on  | m.hazard_on) & blink_phase_nxt;
    lamps_nxt.right_lamp = (m.right_on | m.hazard_on) & blink_phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_hold_r   <= '0;
      right_hold_r  <= '0;
      blink_count_r <= '0;
      blink_phase_r <= 1'b0;
      mode_r        <= '0;
    end else if (step_en) begin
      left_hold_r   <= left_hold_nxt;
      right_hold_r  <= right_hold_nxt;
      blink_count_r <= blink_count_nxt;
      blink_phase_r <= blink_phase_nxt;
      mode_r        <= mode_nxt;
    end
  end

  assign mode = mode_r;

endmodule

// ----- rtl/turn_indicator_controller_top.sv -----
// Top level of the turn indicator controller: input register, state update,
// result register. Depends on tic_pkg, tic_cfg, tic_core and the macro header.
//
//   channel | ports                                  | direction
//   input   | in_valid, in_stall, in_data            | button levels in
//   result  | out_valid, out_stall, out_data         | lamp drive out
//   config  | cfg_we, cfg_idx, cfg_wdata             | register writes
//
// One request per cycle sustained while the result is not stalled; a request passes
// the input register, then the state update into the result register.
// rst_n is synchronous: clears both stage valids, modes, counters, loads
// hold_ticks = 10 and blink_ticks = 3.
// A stalled result holds; the input register still takes one request behind it.
`include "turn_indicator_controller_top_macros.svh"

module turn_indicator_controller_top
  import tic_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tic_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tic_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CntW-1:0]    cfg_wdata
);

  logic      s1_valid_r, s1_valid_nxt;
  tic_in_t   s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  tic_out_t  out_data_r;
  logic      out_blocked;
  logic      s1_go;
  logic      in_take;
  tic_cfg_t  cfg;
  tic_out_t  lamps_nxt;
  tic_mode_t mode;

  assign out_blocked = out_valid_r & out_stall;
  assign s1_go       = s1_valid_r & ~out_blocked;
  assign in_stall    = s1_valid_r & out_blocked;
  assign in_take     = in_valid & ~in_stall;

  tic_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tic_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_go),
    .press     (s1_data_r),
    .cfg       (cfg),
    .lamps_nxt (lamps_nxt),
    .mode      (mode)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take)    s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_go)             out_valid_nxt = 1'b1;
    else if (!out_stall)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (s1_go)   out_data_r <= lamps_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a request waiting behind a stalled result is kept
  `TIC_ASSERT_NEXT(a_s1_kept, s1_valid_r && !s1_go, s1_valid_r)
  // a request leaving the input register shows up as a result
  `TIC_ASSERT_NEXT(a_s1_to_out, s1_go, out_valid_r)
  // hazard and the two side modes never overlap
  `TIC_ASSERT_NOW(a_mode_excl, 1'b1, $onehot0({mode.left_on, mode.right_on, mode.hazard_on}))

endmodule
